FILE: rtl/led_pattern_player_tick_unit_macros.svh
// Assertion macros used by the assertion checker of the LED pattern player.
`ifndef LED_PATTERN_PLAYER_TICK_UNIT_MACROS_SVH
`define LED_PATTERN_PLAYER_TICK_UNIT_MACROS_SVH

// Checked on every clock edge while reset is released.
`define LPPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define LPPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/lppt_pkg.sv
package lppt_pkg;

    // Default depth of the program table.
    localparam int TABLE_DEPTH_DEF = 256;

    // Beat widths on the stream ports.
    localparam int OP_W    = 2;
    localparam int SDATA_W = 32;
    localparam int MDATA_W = 24;

    // Bit counter value after the first bit of a fresh pattern has been shown.
    localparam logic [3:0] PAT_BITS_AFTER_FIRST = 4'd7;

    // Item kinds carried on s_tuser.
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_LOAD   = 2'd1,
        OP_SELECT = 2'd2,
        OP_WRITE  = 2'd3
    } opcode_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_WAIT_CNT,
        ST_WAIT_RST,
        ST_WAIT_PAT,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;       // apply the accepted item
        logic rd_issue;      // read one table byte, advance the read pointer
        logic rd_from_start; // take that read from the program start
        logic load_rep;      // repeat counter from read data
        logic step_shift;    // show the next bit of the running pattern
        logic reload_shift;  // replay the current pattern, one repeat used
        logic load_pat;      // new pattern from read data, show its first bit
        logic set_fault;     // stop playback, LED off
        logic out_load;      // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_tick;   // the offered item is a tick
        logic active;    // a program is selected and not faulted
        logic bits_zero; // no bits left in the running pattern
        logic rep_zero;  // no repeats left
        logic rd_zero;   // registered read data is zero
        logic out_free;  // output register can take a result
    } status_t;

endpackage

FILE: rtl/lppt_datapath.sv
module lppt_datapath #(
    parameter int TABLE_DEPTH = lppt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lppt_pkg::cmd_t               cmd,
    output lppt_pkg::status_t            status,
    input  lppt_pkg::opcode_t            in_opcode,
    input  logic [15:0]                  in_value,
    input  logic [7:0]                   in_index,
    input  logic [7:0]                   in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lppt_pkg::MDATA_W-1:0] out_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // Address wrap: the largest multiple of the depth, up to 15x, not above it is removed.
    function automatic logic [AW-1:0] wrap_addr(input logic [7:0] a);
        logic [7:0] r;
        r = a;
        for (int k = 1; k < 16; k++)
        begin
            if (32'(a) >= k * TABLE_DEPTH)
                r = 8'(32'(a) - k * TABLE_DEPTH);
        end
        return r[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
        return (a == AW'(TABLE_DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    logic [7:0]    mem [TABLE_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;

    logic [7:0]    start_index_reg, start_index_next;
    logic [AW-1:0] start_addr_reg, start_addr_next;
    logic [AW-1:0] read_index_reg, read_index_next;
    logic [7:0]    repeat_left_reg, repeat_left_next;
    logic [7:0]    current_pattern_reg, current_pattern_next;
    logic [7:0]    shift_bits_reg, shift_bits_next;
    logic [3:0]    bits_left_reg, bits_left_next;
    logic [15:0]   tick_count_reg, tick_count_next;
    logic          led_level_reg, led_level_next;
    logic          fault_flag_reg, fault_flag_next;
    logic          out_valid_reg, out_valid_next;
    logic [lppt_pkg::MDATA_W-1:0] out_data_reg;
    logic          wr_en;

    assign wr_en   = cmd.capture && (in_opcode == lppt_pkg::OP_WRITE);
    assign rd_addr = cmd.rd_from_start ? start_addr_reg : read_index_reg;

    // Program table: one write port for table writes, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wrap_addr(in_index)] <= in_data;
        if (cmd.rd_issue)
            rd_data_reg <= mem[rd_addr];
    end

    // Next state of the player and the countdown.
    always_comb
    begin
        start_index_next     = start_index_reg;
        start_addr_next      = start_addr_reg;
        read_index_next      = read_index_reg;
        repeat_left_next     = repeat_left_reg;
        current_pattern_next = current_pattern_reg;
        shift_bits_next      = shift_bits_reg;
        bits_left_next       = bits_left_reg;
        tick_count_next      = tick_count_reg;
        led_level_next       = led_level_reg;
        fault_flag_next      = fault_flag_reg;

        if (cmd.capture)
        begin
            unique case (in_opcode)
                lppt_pkg::OP_TICK:
                begin
                    if (tick_count_reg != 16'd0)
                        tick_count_next = tick_count_reg - 16'd1;
                end
                lppt_pkg::OP_LOAD:
                begin
                    tick_count_next = in_value;
                end
                lppt_pkg::OP_SELECT:
                begin
                    start_index_next = in_index;
                    start_addr_next  = wrap_addr(in_index);
                    read_index_next  = wrap_addr(in_index);
                    repeat_left_next = 8'd0;
                    bits_left_next   = 4'd0;
                    shift_bits_next  = 8'd0;
                    fault_flag_next  = 1'b0;
                end
                lppt_pkg::OP_WRITE:
                begin
                    // The table port handles the write.
                end
            endcase
        end

        if (cmd.rd_issue)
            read_index_next = next_addr(rd_addr);

        if (cmd.load_rep)
            repeat_left_next = rd_data_reg;

        if (cmd.step_shift)
        begin
            bits_left_next  = bits_left_reg - 4'd1;
            led_level_next  = shift_bits_reg[0];
            shift_bits_next = shift_bits_reg >> 1;
        end

        if (cmd.reload_shift)
        begin
            repeat_left_next = repeat_left_reg - 8'd1;
            bits_left_next   = lppt_pkg::PAT_BITS_AFTER_FIRST;
            led_level_next   = current_pattern_reg[0];
            shift_bits_next  = current_pattern_reg >> 1;
        end

        if (cmd.load_pat)
        begin
            current_pattern_next = rd_data_reg;
            bits_left_next       = lppt_pkg::PAT_BITS_AFTER_FIRST;
            led_level_next       = rd_data_reg[0];
            shift_bits_next      = rd_data_reg >> 1;
        end

        if (cmd.set_fault)
        begin
            fault_flag_next = 1'b1;
            led_level_next  = 1'b0;
        end
    end

    // Output register: filled at the end of an item, emptied by the sink.
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_index_reg     <= 8'd0;
            start_addr_reg      <= '0;
            read_index_reg      <= '0;
            repeat_left_reg     <= 8'd0;
            current_pattern_reg <= 8'd0;
            shift_bits_reg      <= 8'd0;
            bits_left_reg       <= 4'd0;
            tick_count_reg      <= 16'd0;
            led_level_reg       <= 1'b0;
            fault_flag_reg      <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            start_index_reg     <= start_index_next;
            start_addr_reg      <= start_addr_next;
            read_index_reg      <= read_index_next;
            repeat_left_reg     <= repeat_left_next;
            current_pattern_reg <= current_pattern_next;
            shift_bits_reg      <= shift_bits_next;
            bits_left_reg       <= bits_left_next;
            tick_count_reg      <= tick_count_next;
            led_level_reg       <= led_level_next;
            fault_flag_reg      <= fault_flag_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Result beat: led_on, countdown, countdown_zero, program_fault from bit 0 up.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= {5'd0, fault_flag_reg, (tick_count_reg == 16'd0),
                             tick_count_reg, led_level_reg};
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Status back to the controller.
    assign status.in_tick   = (in_opcode == lppt_pkg::OP_TICK);
    assign status.active    = (start_index_reg != 8'd0) && !fault_flag_reg;
    assign status.bits_zero = (bits_left_reg == 4'd0);
    assign status.rep_zero  = (repeat_left_reg == 8'd0);
    assign status.rd_zero   = (rd_data_reg == 8'd0);
    assign status.out_free  = !out_valid_reg || out_ready;

endmodule

FILE: rtl/lppt_ctrl.sv
module lppt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lppt_pkg::status_t  status,
    output lppt_pkg::cmd_t     cmd
);

    lppt_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lppt_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            lppt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.in_tick ? lppt_pkg::ST_TICK : lppt_pkg::ST_DONE;
                end
            end
            lppt_pkg::ST_TICK:
            begin
                // The countdown has moved already; now advance playback.
                priority if (!status.active)
                    state_next = lppt_pkg::ST_DONE;
                else if (!status.bits_zero)
                begin
                    cmd.step_shift = 1'b1;
                    state_next     = lppt_pkg::ST_DONE;
                end
                else if (!status.rep_zero)
                begin
                    cmd.reload_shift = 1'b1;
                    state_next       = lppt_pkg::ST_DONE;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = lppt_pkg::ST_WAIT_CNT;
                end
            end
            lppt_pkg::ST_WAIT_CNT:
            begin
                // A zero count sends playback back to the program start.
                cmd.rd_issue = 1'b1;
                if (status.rd_zero)
                begin
                    cmd.rd_from_start = 1'b1;
                    state_next        = lppt_pkg::ST_WAIT_RST;
                end
                else
                begin
                    cmd.load_rep = 1'b1;
                    state_next   = lppt_pkg::ST_WAIT_PAT;
                end
            end
            lppt_pkg::ST_WAIT_RST:
            begin
                // A zero count at the start itself is a faulty program.
                if (status.rd_zero)
                begin
                    cmd.set_fault = 1'b1;
                    state_next    = lppt_pkg::ST_DONE;
                end
                else
                begin
                    cmd.load_rep = 1'b1;
                    cmd.rd_issue = 1'b1;
                    state_next   = lppt_pkg::ST_WAIT_PAT;
                end
            end
            lppt_pkg::ST_WAIT_PAT:
            begin
                cmd.load_pat = 1'b1;
                state_next   = lppt_pkg::ST_DONE;
            end
            lppt_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lppt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lppt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/led_pattern_player_tick_unit.sv
// LED pattern player with a tick countdown. Each input beat is one item: a tick, a countdown
// load, a program select or a table byte write, and each item yields exactly one result beat
// holding the state after it. Items are taken one at a time. Loads, selects and writes go
// straight from acceptance to the result stage; a tick that only shifts the running pattern,
// or finds playback idle, passes the tick state first, one that fetches a new count and
// pattern pair also waits for the count and the pattern bytes, and one that restarts at the
// program start also waits for the count read there (and faults if that count is zero).
// These waits come from the program table's single read port with registered read data.
// A new item is taken as soon as the previous result is in the output register, even if
// that result has not yet been taken. The table has no reset; reading a byte that was never
// written gives an undefined LED pattern.
module led_pattern_player_tick_unit #(
    parameter int TABLE_DEPTH = lppt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lppt_pkg::OP_W-1:0]    s_tuser,  // opcode
    input  logic [lppt_pkg::SDATA_W-1:0] s_tdata,  // value[15:0], index[7:0], data[7:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // led_on, countdown[15:0], countdown_zero, program_fault, zero fill
    output logic [lppt_pkg::MDATA_W-1:0] m_tdata
);

    lppt_pkg::cmd_t    cmd;
    lppt_pkg::status_t status;

    // Sequencer for one item at a time.
    lppt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Player state, program table and result register.
    lppt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_opcode (lppt_pkg::opcode_t'(s_tuser)),
        .in_value  (s_tdata[15:0]),
        .in_index  (s_tdata[23:16]),
        .in_data   (s_tdata[31:24]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

FILE: rtl/lppt_checker.sv
`include "led_pattern_player_tick_unit_macros.svh"

module lppt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [lppt_pkg::MDATA_W-1:0] m_tdata
);

    // A stalled result beat stays put.
    `LPPT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // The zero flag follows the countdown value.
    `LPPT_ASSERT(a_zero_flag, m_tvalid |-> (m_tdata[17] == (m_tdata[16:1] == 16'd0)), "countdown_zero disagrees with countdown")

    // A faulted program keeps the LED dark.
    `LPPT_ASSERT(a_fault_dark, m_tvalid && m_tdata[18] |-> !m_tdata[0], "LED lit while program faulted")

    // Items are worked one at a time.
    `LPPT_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "second item taken while busy")

    // Once reset has been seen at an edge, no result is offered at the next one.
    `LPPT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "result offered during reset")

endmodule

bind led_pattern_player_tick_unit lppt_checker u_lppt_checker (.*);

FILE: dv/led_pattern_player_tick_unit_tb.sv
module led_pattern_player_tick_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // One input item and the visible state after it.
    typedef struct packed {
        lppt_pkg::opcode_t op;
        logic [15:0]       value;
        logic [7:0]        index;
        logic [7:0]        data;
    } item_t;

    typedef struct packed {
        logic        led;
        logic [15:0] count;
        logic        zero;
        logic        fault;
    } player_view_t;

    // Full player state plus a record of which table bytes hold a written value.
    typedef struct packed {
        logic [255:0][7:0] tbl;
        logic [255:0]      known;
        logic [7:0]        start;
        logic [7:0]        rd_ptr;
        logic [7:0]        reps;
        logic [7:0]        pat;
        logic [7:0]        shreg;
        logic [3:0]        nbits;
        logic [15:0]       count;
        logic              led;
        logic              fault;
        logic              blank;    // a read touched a byte never written
        logic [7:0]        blank_at; // first such address
    } player_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [lppt_pkg::OP_W-1:0]      s_tuser = '0;    // opcode
    logic [lppt_pkg::SDATA_W-1:0]   s_tdata = '0;    // value[15:0], index[7:0], data[7:0]
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [lppt_pkg::MDATA_W-1:0]   m_tdata;  // led_on, countdown[15:0], zero, fault, fill

    // Stimulus, prediction and bookkeeping.
    player_t      plan;    // state seen by the stimulus generator
    player_t      model;   // state advanced by accepted beats
    item_t        items_to_send[$];
    player_view_t due_views[$];
    item_t        s_item = '0;
    logic         s_fire = 1'b0;
    int           n_total = 1;
    int           n_sent = 0;
    int           n_checked = 0;
    int           n_errors = 0;
    int           n_fault_views = 0;
    int           op_seen[4] = '{0, 0, 0, 0};

    led_pattern_player_tick_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // Read one table byte and advance the read pointer.
    function automatic logic [7:0] read_next(inout player_t p);
        logic [7:0] b;
        if (!p.known[p.rd_ptr] && !p.blank)
        begin
            p.blank    = 1'b1;
            p.blank_at = p.rd_ptr;
        end
        b        = p.tbl[p.rd_ptr];
        p.rd_ptr = p.rd_ptr + 8'd1;
        return b;
    endfunction

    // Apply one item to a player state.
    function automatic void advance_player(inout player_t p, input item_t it);
        logic [7:0] c;
        logic       halted;
        halted = 1'b0;
        case (it.op)
            lppt_pkg::OP_TICK:
            begin
                if (p.count != 16'd0)
                    p.count = p.count - 16'd1;
                if (p.start != 8'd0 && !p.fault)
                begin
                    if (p.nbits == 4'd0)
                    begin
                        if (p.reps == 8'd0)
                        begin
                            c = read_next(p);
                            // End of program: go back to its start.
                            if (c == 8'd0)
                            begin
                                p.rd_ptr = p.start;
                                c = read_next(p);
                                // Program opens with a zero count: stop with a fault.
                                if (c == 8'd0)
                                begin
                                    p.fault = 1'b1;
                                    p.led   = 1'b0;
                                    halted  = 1'b1;
                                end
                            end
                            if (!halted)
                            begin
                                p.reps = c;
                                p.pat  = read_next(p);
                            end
                        end
                        else
                        begin
                            p.reps = p.reps - 8'd1;
                        end
                        if (!halted)
                        begin
                            p.shreg = p.pat;
                            p.nbits = 4'd8;
                        end
                    end
                    if (!halted)
                    begin
                        p.nbits = p.nbits - 4'd1;
                        p.led   = p.shreg[0];
                        p.shreg = p.shreg >> 1;
                    end
                end
            end
            lppt_pkg::OP_LOAD:
            begin
                p.count = it.value;
            end
            lppt_pkg::OP_SELECT:
            begin
                p.start  = it.index;
                p.rd_ptr = it.index;
                p.reps   = 8'd0;
                p.nbits  = 4'd0;
                p.shreg  = 8'd0;
                p.fault  = 1'b0;
            end
            lppt_pkg::OP_WRITE:
            begin
                p.tbl[it.index]   = it.data;
                p.known[it.index] = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic item_t make_item(lppt_pkg::opcode_t op, logic [15:0] value,
                                        logic [7:0] index, logic [7:0] data);
        item_t it;
        it.op    = op;
        it.value = value;
        it.index = index;
        it.data  = data;
        return it;
    endfunction

    // Queue an item. A tick that would read a never-written byte first gets
    // table writes that fill the bytes it needs.
    function automatic void schedule_item(item_t it);
        player_t trial;
        item_t   fill;
        if (it.op == lppt_pkg::OP_TICK)
        begin
            trial       = plan;
            trial.blank = 1'b0;
            advance_player(trial, it);
            while (trial.blank)
            begin
                fill = make_item(lppt_pkg::OP_WRITE, 16'($urandom), trial.blank_at,
                                 ($urandom_range(0, 3) == 0) ? 8'd0
                                                             : 8'($urandom_range(1, 255)));
                advance_player(plan, fill);
                items_to_send.push_back(fill);
                trial       = plan;
                trial.blank = 1'b0;
                advance_player(trial, it);
            end
        end
        advance_player(plan, it);
        items_to_send.push_back(it);
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Sender: a new beat once the previous one has gone, with random gaps per phase.
    always @(negedge clk)
    begin : drive_items
        item_t nxt;
        int    idle_pct;
        case ((n_sent * 3) / n_total)
            0:       idle_pct = 35;
            1:       idle_pct = 79;
            default: idle_pct = 0;
        endcase
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_fire)
        begin
            if (items_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                nxt = items_to_send.pop_front();
                s_item   <= nxt;
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.op;
                s_tdata  <= {nxt.data, nxt.index, nxt.value};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls per phase.
    always @(negedge clk)
    begin : drive_ready
        int stall_pct;
        case ((n_sent * 3) / n_total)
            0:       stall_pct = 79;
            1:       stall_pct = 35;
            default: stall_pct = 0;
        endcase
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Predict on every accepted input beat and check every accepted result beat.
    always @(posedge clk)
    begin : check_results
        player_view_t want;
        s_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            advance_player(model, s_item);
            want.led   = model.led;
            want.count = model.count;
            want.zero  = (model.count == 16'd0);
            want.fault = model.fault;
            due_views.push_back(want);
            op_seen[s_item.op]++;
            n_sent++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_views.size() == 0)
            begin
                flag_mismatch("result beat with nothing expected", 1, 0);
            end
            else
            begin
                want = due_views.pop_front();
                n_checked++;
                if (want.fault)
                    n_fault_views++;
                if (m_tdata[0] != want.led)
                    flag_mismatch("led_on", m_tdata[0], want.led);
                if (m_tdata[16:1] != want.count)
                    flag_mismatch("countdown", m_tdata[16:1], want.count);
                if (m_tdata[17] != want.zero)
                    flag_mismatch("countdown_zero", m_tdata[17], want.zero);
                if (m_tdata[18] != want.fault)
                    flag_mismatch("program_fault", m_tdata[18], want.fault);
            end
        end
    end

    // Build the stimulus, release reset and wait for the last result.
    initial
    begin : run_test
        int         pick;
        int         npairs;
        int         r;
        logic [7:0] s;
        logic [7:0] a;

        plan  = '0;
        model = '0;

        // Directed: countdown extremes and floor at zero.
        schedule_item(make_item(lppt_pkg::OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom)));
        schedule_item(make_item(lppt_pkg::OP_LOAD, 16'hFFFF, 8'($urandom), 8'($urandom)));
        schedule_item(make_item(lppt_pkg::OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom)));
        schedule_item(make_item(lppt_pkg::OP_LOAD, 16'd0, 8'($urandom), 8'($urandom)));
        schedule_item(make_item(lppt_pkg::OP_LOAD, 16'd1, 8'($urandom), 8'($urandom)));
        schedule_item(make_item(lppt_pkg::OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom)));
        schedule_item(make_item(lppt_pkg::OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom)));

        // Directed: a program at the top of the table whose end wraps to address zero.
        schedule_item(make_item(lppt_pkg::OP_WRITE, 16'($urandom), 8'd254, 8'd1));
        schedule_item(make_item(lppt_pkg::OP_WRITE, 16'($urandom), 8'd255, 8'hA5));
        schedule_item(make_item(lppt_pkg::OP_WRITE, 16'($urandom), 8'd0, 8'd0));
        schedule_item(make_item(lppt_pkg::OP_SELECT, 16'($urandom), 8'd254, 8'($urandom)));
        repeat (3)
            schedule_item(make_item(lppt_pkg::OP_TICK, 16'($urandom), 8'($urandom),
                                    8'($urandom)));

        // Directed: idle playback keeps the LED level.
        schedule_item(make_item(lppt_pkg::OP_SELECT, 16'($urandom), 8'd0, 8'($urandom)));
        schedule_item(make_item(lppt_pkg::OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom)));

        // Directed: a program that opens with a zero count faults; a select clears it.
        schedule_item(make_item(lppt_pkg::OP_WRITE, 16'($urandom), 8'd10, 8'd0));
        schedule_item(make_item(lppt_pkg::OP_SELECT, 16'($urandom), 8'd10, 8'($urandom)));
        schedule_item(make_item(lppt_pkg::OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom)));
        schedule_item(make_item(lppt_pkg::OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom)));
        schedule_item(make_item(lppt_pkg::OP_SELECT, 16'($urandom), 8'd10, 8'($urandom)));
        schedule_item(make_item(lppt_pkg::OP_TICK, 16'($urandom), 8'($urandom), 8'($urandom)));
        schedule_item(make_item(lppt_pkg::OP_WRITE, 16'($urandom), 8'd17, 8'd255));
        schedule_item(make_item(lppt_pkg::OP_SELECT, 16'($urandom), 8'd0, 8'($urandom)));

        // Random: mostly complete programs played for a while, plus faults, idle and noise.
        while (items_to_send.size() < 1650)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                s = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(248, 255))
                                                : 8'($urandom_range(1, 255));
                a = s;
                npairs = $urandom_range(1, 3);
                repeat (npairs)
                begin
                    schedule_item(make_item(lppt_pkg::OP_WRITE, 16'($urandom), a,
                                            ($urandom_range(0, 7) == 0)
                                                ? 8'($urandom_range(1, 255))
                                                : 8'($urandom_range(1, 2))));
                    a = a + 8'd1;
                    schedule_item(make_item(lppt_pkg::OP_WRITE, 16'($urandom), a,
                                            8'($urandom)));
                    a = a + 8'd1;
                end
                // Most programs end with a zero count that sends playback back to the start.
                if ($urandom_range(0, 9) != 0)
                    schedule_item(make_item(lppt_pkg::OP_WRITE, 16'($urandom), a, 8'd0));
                schedule_item(make_item(lppt_pkg::OP_SELECT, 16'($urandom), s, 8'($urandom)));
                repeat ($urandom_range(10, 70))
                begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        schedule_item(make_item(lppt_pkg::OP_LOAD,
                                                $urandom_range(0, 1) ? 16'($urandom_range(0, 40))
                                                                     : 16'($urandom),
                                                8'($urandom), 8'($urandom)));
                    else if (r == 1)
                        schedule_item(make_item(lppt_pkg::OP_WRITE, 16'($urandom),
                                                8'($urandom), 8'($urandom)));
                    else
                        schedule_item(make_item(lppt_pkg::OP_TICK, 16'($urandom),
                                                8'($urandom), 8'($urandom)));
                end
            end
            else if (pick < 70)
            begin
                s = 8'($urandom_range(1, 255));
                schedule_item(make_item(lppt_pkg::OP_WRITE, 16'($urandom), s, 8'd0));
                schedule_item(make_item(lppt_pkg::OP_SELECT, 16'($urandom), s, 8'($urandom)));
                repeat ($urandom_range(1, 4))
                    schedule_item(make_item(lppt_pkg::OP_TICK, 16'($urandom), 8'($urandom),
                                            8'($urandom)));
            end
            else if (pick < 80)
            begin
                schedule_item(make_item(lppt_pkg::OP_SELECT, 16'($urandom), 8'd0,
                                        8'($urandom)));
                schedule_item(make_item(lppt_pkg::OP_LOAD, 16'($urandom_range(0, 20)),
                                        8'($urandom), 8'($urandom)));
                repeat ($urandom_range(3, 25))
                    schedule_item(make_item(lppt_pkg::OP_TICK, 16'($urandom), 8'($urandom),
                                            8'($urandom)));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    schedule_item(make_item(lppt_pkg::opcode_t'($urandom_range(0, 3)),
                                            16'($urandom), 8'($urandom), 8'($urandom)));
            end
        end
        n_total = items_to_send.size();

        // Reset, then let the sender and receiver run.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_total || due_views.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d beats: %0d ticks, %0d loads, %0d selects, %0d table writes.",
                 n_sent, op_seen[lppt_pkg::OP_TICK], op_seen[lppt_pkg::OP_LOAD],
                 op_seen[lppt_pkg::OP_SELECT], op_seen[lppt_pkg::OP_WRITE]);
        $display("Checked %0d result beats, %0d of them with the program fault set.",
                 n_checked, n_fault_views);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("Timeout: %0d of %0d beats sent, %0d results still due.",
                 n_sent, n_total, due_views.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
